@@ rtl/tc8_pkg.sv @@
`timescale 1ns / 1ps

package tc8_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [2:0] REG_CLOCK_SELECT = 3'd1;
  localparam logic [2:0] REG_COMPARE      = 3'd2;
  localparam logic [2:0] REG_PIN_MODE     = 3'd3;
  localparam logic [2:0] REG_OVF_IRQ_EN   = 3'd4;
  localparam logic [2:0] REG_CMP_IRQ_EN   = 3'd5;

  // Waveform modes; the unused code behaves as normal mode.
  localparam logic [1:0] WAVE_NORMAL = 2'd0;
  localparam logic [1:0] WAVE_CTC    = 2'd1;
  localparam logic [1:0] WAVE_PWM    = 2'd2;

  // Pin modes; the unused code acts as disconnected.
  localparam logic [1:0] PIN_OFF    = 2'd0;
  localparam logic [1:0] PIN_NONINV = 2'd1;
  localparam logic [1:0] PIN_INV    = 2'd2;

  // Clock selects; the unused codes stop the counter.
  localparam logic [2:0] CS_STOP    = 3'd0;
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;

  localparam int PRESCALE_BITS = 10;

  typedef struct packed {
    logic [1:0] wave_mode;
    logic [2:0] clock_select;
    logic [7:0] compare_value;
    logic [1:0] pin_mode;
    logic       overflow_irq_enable;
    logic       compare_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic       irq;
    logic       wave_out;
    logic       compare_flag;
    logic       overflow_flag;
    logic [7:0] count_value;
  } result_t;

  // Last prescaler count before a timer step, per clock select.
  function automatic logic [PRESCALE_BITS-1:0] terminal_count(input logic [2:0] sel);
    logic [PRESCALE_BITS-1:0] tc;
    unique case (sel)
      CS_DIV1:    tc = PRESCALE_BITS'(0);
      CS_DIV8:    tc = PRESCALE_BITS'(7);
      CS_DIV64:   tc = PRESCALE_BITS'(63);
      CS_DIV256:  tc = PRESCALE_BITS'(255);
      CS_DIV1024: tc = PRESCALE_BITS'(1023);
      default:    tc = '0;
    endcase
    return tc;
  endfunction

  function automatic logic clock_running(input logic [2:0] sel);
    return (sel >= CS_DIV1) && (sel <= CS_DIV1024);
  endfunction

endpackage

@@ rtl/tc8_prescaler.sv @@
`timescale 1ns / 1ps

module tc8_prescaler (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic [2:0] clock_select,
  output logic       step
);

  logic [tc8_pkg::PRESCALE_BITS-1:0] prescale_count;
  logic [tc8_pkg::PRESCALE_BITS-1:0] prescale_count_next;
  logic                              running;
  logic                              at_end;

  // A count already past a newly chosen, shorter period also fires.
  assign running = tc8_pkg::clock_running(clock_select);
  assign at_end  = prescale_count >= tc8_pkg::terminal_count(clock_select);
  assign step    = tick && running && at_end;

  always_comb begin
    prescale_count_next = prescale_count;
    if (tick && running) begin
      prescale_count_next = at_end ? '0 : prescale_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else begin
      prescale_count <= prescale_count_next;
    end
  end

endmodule

@@ rtl/tc8_core.sv @@
`timescale 1ns / 1ps

module tc8_core #(
  parameter int COUNTER_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  tc8_pkg::op_t        op,
  input  logic [7:0]          write_data,
  input  logic                step,
  input  tc8_pkg::cfg_t       cfg,
  output tc8_pkg::result_t    result
);

  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;

  logic [COUNTER_BITS-1:0] counter;
  logic [COUNTER_BITS-1:0] counter_next;
  logic                    ovf_flag;
  logic                    ovf_flag_next;
  logic                    cmp_flag;
  logic                    cmp_flag_next;
  logic                    pin_level;
  logic                    pin_level_next;
  logic                    match;
  logic                    wrapped;
  logic                    pin_on;
  logic                    at_bottom;

  assign match     = counter == COUNTER_BITS'(cfg.compare_value);
  assign pin_on    = (cfg.pin_mode == tc8_pkg::PIN_NONINV) ||
                     (cfg.pin_mode == tc8_pkg::PIN_INV);
  assign at_bottom = cfg.pin_mode == tc8_pkg::PIN_NONINV;

  always_comb begin
    counter_next   = counter;
    ovf_flag_next  = ovf_flag;
    cmp_flag_next  = cmp_flag;
    pin_level_next = pin_level;
    wrapped        = 1'b0;
    unique case (op)
      tc8_pkg::OP_TICK: begin
        if (step) begin
          if (match) begin
            cmp_flag_next = 1'b1;
          end
          if (cfg.wave_mode == tc8_pkg::WAVE_CTC && match) begin
            counter_next = '0;
          end else if (counter == COUNT_MAX) begin
            counter_next  = '0;
            wrapped       = 1'b1;
            ovf_flag_next = 1'b1;
          end else begin
            counter_next = counter + 1'b1;
          end
          // In fast PWM a wrap on the same step as a match wins.
          if (cfg.wave_mode == tc8_pkg::WAVE_PWM && pin_on) begin
            if (wrapped) begin
              pin_level_next = at_bottom;
            end else if (match) begin
              pin_level_next = !at_bottom;
            end
          end
        end
      end
      tc8_pkg::OP_WRITE: begin
        counter_next = COUNTER_BITS'(write_data);
      end
      tc8_pkg::OP_CLEAR: begin
        if (write_data[0]) begin
          ovf_flag_next = 1'b0;
        end
        if (write_data[1]) begin
          cmp_flag_next = 1'b0;
        end
      end
      tc8_pkg::OP_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.count_value   = counter_next[7:0];
    result.overflow_flag = ovf_flag_next;
    result.compare_flag  = cmp_flag_next;
    result.wave_out      = pin_on && pin_level_next;
    result.irq           = (ovf_flag_next && cfg.overflow_irq_enable) ||
                           (cmp_flag_next && cfg.compare_irq_enable);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      ovf_flag  <= 1'b0;
      cmp_flag  <= 1'b0;
      pin_level <= 1'b0;
    end else if (advance) begin
      counter   <= counter_next;
      ovf_flag  <= ovf_flag_next;
      cmp_flag  <= cmp_flag_next;
      pin_level <= pin_level_next;
    end
  end

endmodule

@@ rtl/timer_counter_8bit_ovf_ctc_pwm.sv @@
`timescale 1ns / 1ps

// Timer/counter with normal, clear-on-compare and fast PWM modes. Each input
// word is a tick, a counter load, a write-one-to-clear of the flags, or a
// read, and each one returns exactly one result word holding the counter, the
// overflow and compare flags, the waveform pin level and the interrupt
// request as they stand after that word. The block takes one input word per
// clock while the output is drained: the prescaler and the counter update
// in the cycle the word is accepted, and the result is registered. A
// two-deep output stage (result register plus skid register) lets an input
// word be accepted while a result is still waiting on the output.
// Configuration writes are always ready and take effect on the next
// accepted word; write them only while the block is idle.
module timer_counter_8bit_ovf_ctc_pwm #(
  parameter int COUNTER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_data
  input  logic [1:0]  s_tuser,   // [1:0] op
  // Result words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] count_value, [8] overflow_flag,
                                 // [9] compare_flag, [10] wave_out, [11] irq,
                                 // [15:12] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tc8_pkg::cfg_t    cfg;
  tc8_pkg::result_t result;
  tc8_pkg::result_t out_word;
  tc8_pkg::result_t skid_word;
  logic             out_valid;
  logic             skid_valid;
  logic             push;
  logic             pop;
  logic             step;
  logic             tick;
  tc8_pkg::op_t     op;

  // Configuration registers are always writable; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tc8_pkg::REG_WAVE_MODE:    cfg.wave_mode           <= cfg_data[1:0];
        tc8_pkg::REG_CLOCK_SELECT: cfg.clock_select        <= cfg_data[2:0];
        tc8_pkg::REG_COMPARE:      cfg.compare_value       <= cfg_data;
        tc8_pkg::REG_PIN_MODE:     cfg.pin_mode            <= cfg_data[1:0];
        tc8_pkg::REG_OVF_IRQ_EN:   cfg.overflow_irq_enable <= cfg_data[0];
        tc8_pkg::REG_CMP_IRQ_EN:   cfg.compare_irq_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The skid register only fills when the output is stalled, so the input
  // stays open until both output slots are in use.
  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign op       = tc8_pkg::op_t'(s_tuser);
  assign tick     = push && (op == tc8_pkg::OP_TICK);

  tc8_prescaler u_prescaler (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .clock_select (cfg.clock_select),
    .step         (step)
  );

  tc8_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (push),
    .op         (op),
    .write_data (s_tdata),
    .step       (step),
    .cfg        (cfg),
    .result     (result)
  );

  // Output stage: the skid word always moves up first to keep order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_word <= skid_valid ? skid_word : result;
    end else if (push) begin
      skid_word <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_word};

endmodule

@@ dv/timer_counter_8bit_ovf_ctc_pwm_tb.sv @@
`timescale 1ns / 1ps

module timer_counter_8bit_ovf_ctc_pwm_tb;
  import tc8_pkg::*;

  // Cycles with no word moving on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    op_t        op;
    logic [7:0] data;
  } stim_word_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] write_data
  logic [1:0]  s_tuser   = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;          // [7:0] count_value, [8] overflow_flag,
                                 // [9] compare_flag, [10] wave_out, [11] irq
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  timer_counter_8bit_ovf_ctc_pwm #(.COUNTER_BITS(8)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Our own copy of the timer: the registers as last written and the state
  // that the block keeps between words.
  cfg_t       tmr_cfg      = '0;
  logic [9:0] tmr_prescale = '0;
  logic [7:0] tmr_count    = '0;
  logic       tmr_ovf      = 1'b0;
  logic       tmr_cmp      = 1'b0;
  logic       tmr_pin      = 1'b0;

  int unsigned n_steps      = 0;
  int unsigned n_matches    = 0;
  int unsigned n_wraps      = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_errors     = 0;
  int unsigned words_queued = 0;
  int unsigned results_seen = 0;

  stim_word_t pending[$];      // words waiting for the driver
  result_t    due_status[$];   // status words the block still owes us

  bit word_taken   = 1'b0;     // set at the edge that accepts the input word
  bit feed_bursty  = 1'b0;
  bit drain_bursty = 1'b0;
  int unsigned feed_gap    = 0;
  int unsigned drain_stall = 0;

  // Applies one input word to the shadow timer and returns the status word
  // the block must answer with.
  function automatic result_t apply_word(op_t op, logic [7:0] data);
    int unsigned ratio;
    logic        hit;
    logic        wrapped;
    logic        bottom;
    logic        pin_on;
    result_t     r;
    case (op)
      OP_TICK: begin
        case (tmr_cfg.clock_select)
          CS_DIV1:    ratio = 1;
          CS_DIV8:    ratio = 8;
          CS_DIV64:   ratio = 64;
          CS_DIV256:  ratio = 256;
          CS_DIV1024: ratio = 1024;
          default:    ratio = 0;   // stopped, including the unused selects
        endcase
        if (ratio != 0) begin
          // A prescale count left above a smaller, newly chosen divisor also
          // fires at once, hence the compare with >= rather than ==.
          if (32'(tmr_prescale) >= ratio - 1) begin
            tmr_prescale = '0;
            n_steps++;
            // The match is judged on the count before the step.
            hit     = (tmr_count == tmr_cfg.compare_value);
            wrapped = 1'b0;
            if (hit) begin
              tmr_cmp = 1'b1;
              n_matches++;
            end
            if (tmr_cfg.wave_mode == WAVE_CTC && hit) begin
              tmr_count = '0;
            end else if (tmr_count == 8'hFF) begin
              tmr_count = '0;
              wrapped   = 1'b1;
              tmr_ovf   = 1'b1;
              n_wraps++;
            end else begin
              tmr_count = tmr_count + 8'd1;
            end
            // Fast PWM: the pin goes to its bottom level on a wrap and to the
            // other level on a match; a wrap in the same step wins.
            if (tmr_cfg.wave_mode == WAVE_PWM &&
                (tmr_cfg.pin_mode == PIN_NONINV || tmr_cfg.pin_mode == PIN_INV)) begin
              bottom = (tmr_cfg.pin_mode == PIN_NONINV);
              if (hit)     tmr_pin = ~bottom;
              if (wrapped) tmr_pin = bottom;
            end
          end else begin
            tmr_prescale = tmr_prescale + 10'd1;
          end
        end
      end
      OP_WRITE: tmr_count = data;
      OP_CLEAR: begin
        // Write one to clear; the upper bits mean nothing.
        if (data[0]) tmr_ovf = 1'b0;
        if (data[1]) tmr_cmp = 1'b0;
      end
      default: ;
    endcase
    pin_on          = (tmr_cfg.pin_mode == PIN_NONINV || tmr_cfg.pin_mode == PIN_INV);
    r.count_value   = tmr_count;
    r.overflow_flag = tmr_ovf;
    r.compare_flag  = tmr_cmp;
    r.wave_out      = pin_on ? tmr_pin : 1'b0;
    r.irq           = (tmr_ovf & tmr_cfg.overflow_irq_enable) |
                      (tmr_cmp & tmr_cfg.compare_irq_enable);
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_errors++;
    end
  endfunction

  // Mostly no pause, sometimes a short one, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Everything that happens at a rising edge is observed here: register
  // writes update the shadow configuration, accepted input words run through
  // the shadow timer, and accepted status words are compared with the oldest
  // prediction.
  always @(posedge clk) begin : observe
    result_t want;
    result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVE_MODE:    tmr_cfg.wave_mode           = cfg_data[1:0];
          REG_CLOCK_SELECT: tmr_cfg.clock_select        = cfg_data[2:0];
          REG_COMPARE:      tmr_cfg.compare_value       = cfg_data;
          REG_PIN_MODE:     tmr_cfg.pin_mode            = cfg_data[1:0];
          REG_OVF_IRQ_EN:   tmr_cfg.overflow_irq_enable = cfg_data[0];
          REG_CMP_IRQ_EN:   tmr_cfg.compare_irq_enable  = cfg_data[0];
          default: ;
        endcase
        n_cfg_writes++;
      end
      if (s_tvalid && s_tready) begin
        due_status.push_back(apply_word(op_t'(s_tuser), s_tdata));
        word_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = result_t'(m_tdata[11:0]);
        if (due_status.size() == 0) begin
          $display("%0t: status word %h arrived with nothing expected", $time, m_tdata);
          n_errors++;
        end else begin
          want = due_status.pop_front();
          check_field("count_value",   32'(want.count_value),   32'(got.count_value));
          check_field("overflow_flag", 32'(want.overflow_flag), 32'(got.overflow_flag));
          check_field("compare_flag",  32'(want.compare_flag),  32'(got.compare_flag));
          check_field("wave_out",      32'(want.wave_out),      32'(got.wave_out));
          check_field("irq",           32'(want.irq),           32'(got.irq));
          check_field("tdata padding", 0,                       32'(m_tdata[15:12]));
        end
      end
    end
  end

  // Input driver: presents the next pending word once the current one has
  // been taken, with random gaps in between. Stretches with no gaps at all
  // come and go as the bursty mode flips.
  always @(negedge clk) begin : feed
    stim_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      word_taken = 1'b0;
      if (feed_gap != 0) begin
        feed_gap--;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        w = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= w.data;
        if ($urandom_range(0, 99) < 3) feed_bursty = !feed_bursty;
        feed_gap = feed_bursty ? 0 : pause_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side: ready drops for random stretches.
  always @(negedge clk) begin : drain
    if (rst) begin
      m_tready <= 1'b0;
    end else if (drain_stall != 0) begin
      drain_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 3) drain_bursty = !drain_bursty;
      if (!drain_bursty && $urandom_range(0, 99) < 25) drain_stall = pause_len();
    end
  end

  // Watchdog: a correct block moves a word on some channel well within the
  // longest pause either side can insert.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d status words outstanding",
                 $time, quiet, due_status.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_word(op_t op, logic [7:0] data);
    stim_word_t w;
    w.op   = op;
    w.data = data;
    pending.push_back(w);
    words_queued++;
  endtask

  // One register write; valid stays high into the next write of a batch.
  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(cfg_t c);
    write_reg(REG_WAVE_MODE,    8'(c.wave_mode));
    write_reg(REG_CLOCK_SELECT, 8'(c.clock_select));
    write_reg(REG_COMPARE,      c.compare_value);
    write_reg(REG_PIN_MODE,     8'(c.pin_mode));
    write_reg(REG_OVF_IRQ_EN,   8'(c.overflow_irq_enable));
    write_reg(REG_CMP_IRQ_EN,   8'(c.compare_irq_enable));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every word yields one status word, so the block is idle once all have
  // come back.
  task automatic settle();
    while (results_seen < words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run
    cfg_t        c;
    int unsigned r;
    int unsigned k;
    logic [7:0]  d;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings leave the timer stopped: a tick must not move it, a
    // load must, and the upper bits of a flag clear must be ignored.
    queue_word(OP_READ,  8'h00);
    queue_word(OP_TICK,  8'hFF);
    queue_word(OP_WRITE, 8'hFF);
    queue_word(OP_CLEAR, 8'hFC);
    settle();

    // Fast PWM with the compare value at the top: match and wrap land on the
    // same step and the wrap sets the pin. Then clear each flag on its own.
    c = '{wave_mode: WAVE_PWM, clock_select: CS_DIV1, compare_value: 8'hFF,
          pin_mode: PIN_NONINV, overflow_irq_enable: 1'b1, compare_irq_enable: 1'b1};
    load_setup(c);
    queue_word(OP_WRITE, 8'hFD);
    repeat (3) queue_word(OP_TICK, 8'h00);
    queue_word(OP_CLEAR, 8'h01);
    queue_word(OP_CLEAR, 8'h02);
    queue_word(OP_READ,  8'hA5);
    settle();

    // Clear on compare at zero with a slow divider, so the prescaler builds
    // up a count that a faster divider then finds already past its end.
    c = '{wave_mode: WAVE_CTC, clock_select: CS_DIV256, compare_value: 8'h00,
          pin_mode: PIN_INV, overflow_irq_enable: 1'b1, compare_irq_enable: 1'b0};
    load_setup(c);
    queue_word(OP_WRITE, 8'h00);
    repeat (9) queue_word(OP_TICK, 8'h00);
    settle();
    c.clock_select = CS_DIV8;
    load_setup(c);
    repeat (4) queue_word(OP_TICK, 8'h00);
    settle();

    // Random phases, each with its own register setting. Loads aim near the
    // compare value and near the top so that matches and wraps come often.
    for (int ph = 0; ph < 10; ph++) begin
      c.wave_mode = (ph < 2) ? WAVE_PWM : (ph == 2) ? WAVE_CTC : 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if      (ph == 0) c.clock_select = CS_DIV1;
      else if (r < 45)  c.clock_select = CS_DIV1;
      else if (r < 65)  c.clock_select = CS_DIV8;
      else if (r < 75)  c.clock_select = CS_DIV64;
      else if (r < 80)  c.clock_select = CS_DIV256;
      else if (r < 85)  c.clock_select = CS_DIV1024;
      else begin
        k = $urandom_range(0, 2);
        c.clock_select = (k == 0) ? CS_STOP : 3'(5 + k);
      end
      c.compare_value       = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      c.pin_mode            = (ph == 0) ? PIN_NONINV : (ph == 1) ? PIN_INV :
                              2'($urandom_range(0, 3));
      c.overflow_irq_enable = 1'($urandom_range(0, 1));
      c.compare_irq_enable  = 1'($urandom_range(0, 1));
      load_setup(c);

      for (int n = 0; n < 55; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          queue_word(OP_TICK, 8'($urandom_range(0, 255)));
        end else if (r < 70) begin
          k = $urandom_range(0, 99);
          if (k < 40)      d = c.compare_value - 8'($urandom_range(0, 3));
          else if (k < 70) d = 8'hFF - 8'($urandom_range(0, 3));
          else             d = 8'($urandom_range(0, 255));
          queue_word(OP_WRITE, d);
        end else if (r < 85) begin
          queue_word(OP_CLEAR, 8'($urandom_range(0, 255)));
        end else begin
          queue_word(OP_READ, 8'($urandom_range(0, 255)));
        end
      end
      settle();
    end

    if (due_status.size() != 0) begin
      $display("%0t: %0d status words never arrived", $time, due_status.size());
      n_errors++;
    end

    $display("Checked %0d status words over %0d register writes in 14 settings.",
             results_seen, n_cfg_writes);
    $display("The timer stepped %0d times with %0d compare matches and %0d wraps.",
             n_steps, n_matches, n_wraps);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
